@@ src/rgbpcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbpcc_pkg
// Shared widths, codes and constants of the rgb pixel color converter.
// ----------------------------------------------------------------------------
package rgbpcc_pkg;

    localparam int SAMPLE_BITS = 16;

    // pixel sum, gray numerator, divisor, remainder and quotient widths
    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam int DIV_W = SAMPLE_BITS + 2;
    localparam int NUM_W = SUM_W + SAMPLE_BITS;
    localparam int REM_W = NUM_W + 1;
    localparam int Q_W   = SAMPLE_BITS + 1;

    // sepia dot product: at most 1351 * max sample
    localparam int DOT_W   = SAMPLE_BITS + 11;
    localparam int RECIP_W = 28;
    localparam int PROD_W  = DOT_W + RECIP_W;
    localparam int RECIP_SH = 37;
    // ceil(2^37 / 1000), exact floor(x / 1000) for any dot product here
    localparam logic [RECIP_W-1:0] RECIP_K = 28'd137438954;

    localparam int IN_W  = 3 * SAMPLE_BITS;
    localparam int OUT_BITS = 4 * SAMPLE_BITS + 1;
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [9:0]             coef_t;

    // mode codes
    localparam logic [2:0] MODE_BITMAP  = 3'd0;
    localparam logic [2:0] MODE_GRAY    = 3'd1;
    localparam logic [2:0] MODE_ISOLATE = 3'd2;
    localparam logic [2:0] MODE_REMOVE  = 3'd3;
    localparam logic [2:0] MODE_SEPIA   = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_MAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MAX = 2'd3;

    // sepia matrix in thousandths, rows are output channels
    localparam coef_t SEPIA_K [3][3] = '{
        '{10'd393, 10'd769, 10'd189},
        '{10'd349, 10'd686, 10'd168},
        '{10'd272, 10'd534, 10'd131}
    };

endpackage

@@ src/rgb_pixel_color_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_pixel_color_converter
// Pipelined pixel converter: bitmap threshold, gray, isolate, remove, sepia.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         red, green, blue
//  m_axis    out        out_red, out_green, out_blue, gray_value, black_bit
//  cfg       in         register index and write data
//
//  one pixel per clock sustained while m_tready is high
//  most of the pipeline depth is the gray divider, one quotient bit per stage
//  every stage advances together when the output register is empty or taken
//  reset clears valid bits and loads register defaults; no clearing pass
// ----------------------------------------------------------------------------
module rgb_pixel_color_converter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rgbpcc_pkg::IN_W-1:0]   s_tdata,   // red, green, blue
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_red, out_green, out_blue, gray_value, black_bit, zero pad
    output logic [rgbpcc_pkg::OUT_W-1:0]  m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rgbpcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rgbpcc_pkg::CFG_W-1:0]  cfg_data
);
    import rgbpcc_pkg::*;

    localparam int NDIV = Q_W - 1;

    typedef struct packed {
        sample_t             r;
        sample_t             g;
        sample_t             b;
        logic [SUM_W-1:0]    sum;
    } stg_a_t;

    typedef struct packed {
        sample_t [2:0]       pass;
        logic                black;
        logic [NUM_W-1:0]    num;
        logic [2:0][DOT_W-1:0] dot;
    } stg_b_t;

    typedef struct packed {
        sample_t [2:0]       pass;
        logic                black;
        logic [NUM_W-1:0]    num;
        logic [2:0][PROD_W-1:0] prod;
    } stg_c_t;

    typedef struct packed {
        sample_t [2:0]       rgb;
        logic                black;
        logic [REM_W-1:0]    rem;
        logic [Q_W-1:0]      quo;
        logic                ovf;
    } stg_d_t;

    logic [2:0]       mode_reg;
    logic [1:0]       chan_reg;
    sample_t          smax_reg;
    sample_t          gmax_reg;
    logic [DIV_W-1:0] dsr;

    logic             en;
    logic             va_reg, vb_reg, vc_reg, vd_reg;
    logic [NDIV-1:0]  vdiv_reg;
    logic             vo_reg;

    stg_a_t a_reg, a_next;
    stg_b_t b_reg, b_next;
    stg_c_t c_reg, c_next;
    stg_d_t d_reg, d_next;
    stg_d_t div_reg  [NDIV];
    stg_d_t div_next [NDIV];
    logic [OUT_W-1:0] o_reg, o_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BITMAP;
            chan_reg <= 2'd0;
            smax_reg <= sample_t'(255);
            gmax_reg <= sample_t'(255);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODE:     mode_reg <= cfg_data[2:0];
                REG_CHANNEL:  chan_reg <= cfg_data[1:0];
                REG_SRC_MAX:  smax_reg <= sample_t'(cfg_data);
                REG_GRAY_MAX: gmax_reg <= sample_t'(cfg_data);
                default:      ;
            endcase
        end
    end

    // divisor 3 * src_max
    assign dsr = {smax_reg, 1'b0} + DIV_W'(smax_reg);

    assign en       = !vo_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = vo_reg;
    assign m_tdata  = o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            vdiv_reg <= '0;
            vo_reg   <= 1'b0;
        end
        else if (en)
        begin
            va_reg   <= s_tvalid;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            vd_reg   <= vc_reg;
            vdiv_reg <= {vdiv_reg[NDIV-2:0], vd_reg};
            vo_reg   <= vdiv_reg[NDIV-1];
        end
    end

    // stage a: unpack and sum
    always_comb
    begin
        a_next.r   = s_tdata[SAMPLE_BITS-1:0];
        a_next.g   = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        a_next.b   = s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
        a_next.sum = SUM_W'(a_next.r) + SUM_W'(a_next.g) + SUM_W'(a_next.b);
    end

    // stage b: threshold, channel select, gray numerator, sepia dot products
    always_comb
    begin
        sample_t px [3];
        px[0] = a_reg.r;
        px[1] = a_reg.g;
        px[2] = a_reg.b;
        b_next.black = (mode_reg == MODE_BITMAP) &&
                       ({1'b0, a_reg.sum, 1'b0} < {2'b00, dsr});
        for (int k = 0; k < 3; k++)
        begin
            b_next.pass[k] = '0;
            if (mode_reg == MODE_ISOLATE && chan_reg == 2'(k))
                b_next.pass[k] = px[k];
            if (mode_reg == MODE_REMOVE && chan_reg != 2'(k))
                b_next.pass[k] = px[k];
            b_next.dot[k] = DOT_W'(SEPIA_K[k][0]) * DOT_W'(px[0])
                          + DOT_W'(SEPIA_K[k][1]) * DOT_W'(px[1])
                          + DOT_W'(SEPIA_K[k][2]) * DOT_W'(px[2]);
        end
        b_next.num = NUM_W'(a_reg.sum) * NUM_W'(gmax_reg);
    end

    // stage c: divide the dot products by 1000 through the reciprocal
    always_comb
    begin
        c_next.pass  = b_reg.pass;
        c_next.black = b_reg.black;
        c_next.num   = b_reg.num;
        for (int k = 0; k < 3; k++)
            c_next.prod[k] = PROD_W'(b_reg.dot[k]) * PROD_W'(RECIP_K);
    end

    // stage d: sepia saturate, output select, top quotient bit
    always_comb
    begin
        logic [REM_W-1:0]     sh;
        logic [PROD_W-RECIP_SH-1:0] sv;
        sh = REM_W'(dsr) << (Q_W - 1);
        for (int k = 0; k < 3; k++)
        begin
            sv = c_reg.prod[k][PROD_W-1:RECIP_SH];
            if (mode_reg == MODE_SEPIA)
                d_next.rgb[k] = (sv > (PROD_W-RECIP_SH)'(smax_reg)) ? smax_reg
                                                                   : sample_t'(sv);
            else
                d_next.rgb[k] = c_reg.pass[k];
        end
        d_next.black = c_reg.black;
        // a quotient that needs more than Q_W bits is past any gray_max
        d_next.ovf = {1'b0, c_reg.num[NUM_W-1:Q_W]} >= dsr;
        d_next.rem = REM_W'(c_reg.num);
        d_next.quo = '0;
        if (d_next.rem >= sh)
        begin
            d_next.rem = d_next.rem - sh;
            d_next.quo[Q_W-1] = 1'b1;
        end
    end

    // divider stages, one quotient bit each
    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        localparam int BIT = NDIV - 1 - j;
        stg_d_t prev;
        if (j == 0)
        begin : g_first
            assign prev = d_reg;
        end
        else
        begin : g_rest
            assign prev = div_reg[j-1];
        end

        always_comb
        begin
            logic [REM_W-1:0] sh;
            sh = REM_W'(dsr) << BIT;
            div_next[j] = prev;
            if (prev.rem >= sh)
            begin
                div_next[j].rem = prev.rem - sh;
                div_next[j].quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
                div_reg[j] <= div_next[j];
        end
    end

    // output stage: gray clamp and packing
    always_comb
    begin
        stg_d_t  f;
        sample_t gray;
        f = div_reg[NDIV-1];
        gray = '0;
        if (mode_reg == MODE_GRAY)
            gray = (f.ovf || f.quo > Q_W'(gmax_reg)) ? gmax_reg : sample_t'(f.quo);
        o_next = OUT_W'({f.black, gray, f.rgb[2], f.rgb[1], f.rgb[0]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            o_reg <= o_next;
        end
    end

endmodule

@@ src/rgbpcc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbpcc_checker
// Port-level checks of the pixel converter, bound to the top level.
// ----------------------------------------------------------------------------
module rgbpcc_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rgbpcc_pkg::OUT_W-1:0]  m_tdata
);
    import rgbpcc_pkg::*;

    // a held output beat keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // with the output register empty the pipeline must take input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // the black bit only comes in bitmap mode, where all other fields are zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4*SAMPLE_BITS] |-> m_tdata[4*SAMPLE_BITS-1:0] == '0)
        else $error("black bit with nonzero samples");

    // pad bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_W-1:OUT_BITS] == '0)
        else $error("pad bits set");

endmodule

bind rgb_pixel_color_converter rgbpcc_checker u_rgbpcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
